// File: design/cdbfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock divider search package
// Widths, defaults and the command/status types shared by the search blocks.
// ----------------------------------------------------------------------------
package cdbfs_pkg;

	localparam int SRC_W        = 29;
	localparam int TARGET_W     = 29;
	localparam int FREQ_W       = 28;
	localparam int ERR_W        = 29;
	localparam int PSC_CODE_W   = 8;
	localparam int DIV_IDX_W    = 4;
	localparam int PSC_IDX_W    = 3;
	localparam int REM_W        = 4;
	localparam int DIV_STEP_W   = 5;
	localparam int QSLOTS       = 16;

	localparam int DEF_MAX_DIVISOR   = 16;
	localparam int DEF_MAX_PRESCALER = 256;

	localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(120000000);

	typedef struct packed {
		logic                 accept;
		logic                 div_start;
		logic [DIV_IDX_W-1:0] div_idx;
		logic                 step;
		logic [PSC_IDX_W-1:0] psc_idx;
		logic [DIV_IDX_W-1:0] dv_idx;
		logic                 load_out;
	} cdbfs_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} cdbfs_stat_t;

endpackage
`default_nettype wire

// File: design/cdbfs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Base clock divider
// Restoring divider, one quotient bit per cycle: source clock / (1..16).
// ----------------------------------------------------------------------------
module cdbfs_div import cdbfs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SRC_W-1:0]     dividend,
	input  wire logic [DIV_IDX_W-1:0] divisor_idx,
	output logic                      done,
	output logic [SRC_W-1:0]          quotient
);

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [SRC_W-1:0]      dvd_q;
	logic [REM_W-1:0]      rem_q;
	logic [REM_W:0]        dvs_q;
	logic [REM_W:0]        trial;
	logic                  qbit;

	assign trial    = {rem_q, dvd_q[SRC_W-1]};
	assign qbit     = (trial >= dvs_q);
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = {dvd_q[SRC_W-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_STEP_W'(SRC_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= {1'b0, divisor_idx} + 1'b1;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SRC_W-2:0], qbit};
			rem_q <= qbit ? REM_W'(trial - dvs_q) : trial[REM_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: design/cdbfs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Search datapath
// Source clock register, quotient store, candidate compare and result register.
// ----------------------------------------------------------------------------
module cdbfs_dp import cdbfs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [SRC_W-1:0]      cfg_wr_data,
	input  wire logic [TARGET_W-1:0]   target_frequency,
	input  wire logic                  result_stall,
	input  wire cdbfs_cmd_t            cmd,
	output cdbfs_stat_t                stat,
	output logic                       result_valid,
	output logic [PSC_CODE_W-1:0]      prescaler_code,
	output logic [DIV_IDX_W-1:0]       divisor_code,
	output logic [FREQ_W-1:0]          achieved_frequency,
	output logic [ERR_W-1:0]           frequency_error
);

	logic [SRC_W-1:0]     src_q;
	logic [TARGET_W-1:0]  target_q;
	logic [DIV_IDX_W-1:0] wr_idx_q;
	logic [SRC_W-1:0]     qstore_q [QSLOTS];

	logic                 div_done;
	logic [SRC_W-1:0]     quotient;

	logic [FREQ_W-1:0]    best_freq_q;
	logic [ERR_W-1:0]     best_err_q;
	logic [PSC_IDX_W-1:0] best_psc_q;
	logic [DIV_IDX_W-1:0] best_div_q;
	logic                 res_valid_q;

	logic [SRC_W-1:0]     q_rd;
	logic [SRC_W-1:0]     q_shift;
	logic [FREQ_W-1:0]    freq;
	logic [ERR_W-1:0]     freq_ext;
	logic [ERR_W-1:0]     err;
	logic                 take;

	cdbfs_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cmd.div_start),
		.dividend    (src_q),
		.divisor_idx (cmd.div_idx),
		.done        (div_done),
		.quotient    (quotient)
	);

	assign stat.div_done = div_done;
	assign stat.out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			src_q <= SRC_RESET;
		else if (cfg_wr_en)
			src_q <= cfg_wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			target_q <= target_frequency;
		if (cmd.div_start)
			wr_idx_q <= cmd.div_idx;
		if (div_done)
			qstore_q[wr_idx_q] <= quotient;
	end

	// prescaler 2^(k+1): shift the per-divisor quotient right by k+1
	assign q_rd     = qstore_q[cmd.dv_idx];
	assign q_shift  = (q_rd >> 1) >> cmd.psc_idx;
	assign freq     = q_shift[FREQ_W-1:0];
	assign freq_ext = {1'b0, freq};
	assign err      = (target_q > freq_ext) ? (target_q - freq_ext) : (freq_ext - target_q);
	assign take     = (best_freq_q == '0) || (best_err_q > err);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			best_freq_q <= '0;
			best_err_q  <= '0;
			best_psc_q  <= '0;
			best_div_q  <= '0;
		end else if (cmd.step && take) begin
			best_freq_q <= freq;
			best_err_q  <= err;
			best_psc_q  <= cmd.psc_idx;
			best_div_q  <= cmd.dv_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.load_out)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			prescaler_code     <= PSC_CODE_W'(1) << best_psc_q;
			divisor_code       <= best_div_q;
			achieved_frequency <= best_freq_q;
			frequency_error    <= best_err_q;
		end
	end

	assign result_valid = res_valid_q;

endmodule
`default_nettype wire

// File: design/cdbfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Search controller
// Sequences the divisions, the candidate sweep and the result hand-off.
// ----------------------------------------------------------------------------
module cdbfs_ctrl import cdbfs_pkg::*; #(
	parameter int MAX_DIVISOR   = DEF_MAX_DIVISOR,
	parameter int MAX_PRESCALER = DEF_MAX_PRESCALER
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        target_valid,
	output logic             target_stall,
	input  wire cdbfs_stat_t stat,
	output cdbfs_cmd_t       cmd
);

	localparam int NUM_PSC = $clog2(MAX_PRESCALER + 1) - 1;
	localparam logic [DIV_IDX_W-1:0] DIV_LAST = DIV_IDX_W'(MAX_DIVISOR - 1);
	localparam logic [PSC_IDX_W-1:0] PSC_LAST = PSC_IDX_W'(NUM_PSC - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIVIDE = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]           state_q;
	logic [DIV_IDX_W-1:0] div_cnt_q;
	logic [PSC_IDX_W-1:0] psc_cnt_q;
	logic [DIV_IDX_W-1:0] dv_cnt_q;
	logic                 accept;
	logic                 div_last;

	assign target_stall = (state_q != ST_IDLE);
	assign accept       = (state_q == ST_IDLE) && target_valid;
	assign div_last     = (div_cnt_q == DIV_LAST);

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.div_start = accept || ((state_q == ST_DIVIDE) && stat.div_done && !div_last);
		cmd.div_idx   = accept ? '0 : div_cnt_q + 1'b1;
		cmd.step      = (state_q == ST_SEARCH);
		cmd.psc_idx   = psc_cnt_q;
		cmd.dv_idx    = dv_cnt_q;
		cmd.load_out  = (state_q == ST_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			psc_cnt_q <= '0;
			dv_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_DIVIDE;
						div_cnt_q <= '0;
					end
				end
				ST_DIVIDE: begin
					if (stat.div_done) begin
						if (div_last) begin
							state_q   <= ST_SEARCH;
							psc_cnt_q <= '0;
							dv_cnt_q  <= '0;
						end else begin
							div_cnt_q <= div_cnt_q + 1'b1;
						end
					end
				end
				ST_SEARCH: begin
					if (dv_cnt_q == DIV_LAST) begin
						dv_cnt_q <= '0;
						if (psc_cnt_q == PSC_LAST)
							state_q <= ST_FINISH;
						else
							psc_cnt_q <= psc_cnt_q + 1'b1;
					end else begin
						dv_cnt_q <= dv_cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/clock_divider_best_fit_search_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock divider best-fit search
// Picks the prescaler/divisor pair giving the card clock closest to a target.
// ----------------------------------------------------------------------------
// One item is searched at a time; target_stall is high from acceptance until
// the result is placed in the output register. The shared one-bit-per-cycle
// divider forms source/d for every divisor d, then one candidate per cycle is
// compared (log2(MAX_PRESCALER) * MAX_DIVISOR candidates), then the best fit
// is loaded into the result register once that register is free, and the
// block returns to idle to take the next item. The result register lets the
// next item in while the previous result still waits. source_clock_hz is
// written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, as the block does not enforce this. It resets
// to 120 MHz.
module clock_divider_best_fit_search_top import cdbfs_pkg::*; #(
	parameter int MAX_DIVISOR   = DEF_MAX_DIVISOR,
	parameter int MAX_PRESCALER = DEF_MAX_PRESCALER
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [SRC_W-1:0]      cfg_wr_data,
	input  wire logic                  target_valid,
	output logic                       target_stall,
	input  wire logic [TARGET_W-1:0]   target_frequency,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [PSC_CODE_W-1:0]      prescaler_code,
	output logic [DIV_IDX_W-1:0]       divisor_code,
	output logic [FREQ_W-1:0]          achieved_frequency,
	output logic [ERR_W-1:0]           frequency_error
);

	cdbfs_cmd_t  cmd;
	cdbfs_stat_t stat;

	cdbfs_ctrl #(
		.MAX_DIVISOR   (MAX_DIVISOR),
		.MAX_PRESCALER (MAX_PRESCALER)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_valid (target_valid),
		.target_stall (target_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	cdbfs_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.target_frequency   (target_frequency),
		.result_stall       (result_stall),
		.cmd                (cmd),
		.stat               (stat),
		.result_valid       (result_valid),
		.prescaler_code     (prescaler_code),
		.divisor_code       (divisor_code),
		.achieved_frequency (achieved_frequency),
		.frequency_error    (frequency_error)
	);

endmodule
`default_nettype wire

// File: tb/sv/clock_divider_best_fit_search_checker.sv
// ----------------------------------------------------------------------------
// Clock divider best-fit search checker
// Follows base clock writes, forms the best prescaler/divisor fit for every
// accepted target item and compares each result item with the oldest fit due.
// ----------------------------------------------------------------------------
module clock_divider_best_fit_search_checker import cdbfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [SRC_W-1:0]      cfg_wr_data,
	input  logic                  target_valid,
	input  logic                  target_stall,
	input  logic [TARGET_W-1:0]   target_frequency,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  logic [PSC_CODE_W-1:0] prescaler_code,
	input  logic [DIV_IDX_W-1:0]  divisor_code,
	input  logic [FREQ_W-1:0]     achieved_frequency,
	input  logic [ERR_W-1:0]      frequency_error,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_checked
);

	typedef struct packed {
		logic [PSC_CODE_W-1:0] psc_code;
		logic [DIV_IDX_W-1:0]  div_code;
		logic [FREQ_W-1:0]     freq;
		logic [ERR_W-1:0]      err;
	} divider_fit_t;

	logic [SRC_W-1:0] base_clock;
	divider_fit_t     expected_fits[$];
	int               n_bad = 0;
	int               n_checked = 0;

	function automatic divider_fit_t best_divider_fit(input logic [SRC_W-1:0] src,
		input logic [TARGET_W-1:0] target);
		divider_fit_t fit;
		logic [31:0]  cand;
		logic [31:0]  diff;
		logic [31:0]  best_freq;
		logic [31:0]  best_err;
		fit = '0;
		fit.psc_code = PSC_CODE_W'(1);
		best_freq = '0;
		best_err = '0;
		for (int psc = 2; psc <= DEF_MAX_PRESCALER; psc = psc * 2) begin
			for (int dv = 1; dv <= DEF_MAX_DIVISOR; dv++) begin
				cand = 32'(src) / 32'(psc * dv);
				diff = (32'(target) > cand) ? 32'(target) - cand : cand - 32'(target);
				// zero best so far always yields; otherwise only a strictly closer fit
				if (best_freq == 0 || best_err > diff) begin
					best_freq = cand;
					best_err = diff;
					fit.psc_code = PSC_CODE_W'(psc / 2);
					fit.div_code = DIV_IDX_W'(dv - 1);
				end
			end
		end
		fit.freq = FREQ_W'(best_freq);
		fit.err = ERR_W'(best_err);
		return fit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		divider_fit_t got;
		divider_fit_t want;
		if (!arst_n) begin
			base_clock = SRC_RESET;
			expected_fits.delete();
		end else begin
			if (cfg_wr_en)
				base_clock = cfg_wr_data;
			if (result_valid && !result_stall) begin
				got = {prescaler_code, divisor_code, achieved_frequency, frequency_error};
				n_checked++;
				if (expected_fits.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("result %0d arrived with no item outstanding", n_checked);
				end else begin
					want = expected_fits.pop_front();
					if (got != want) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"result %0d: expected psc %0d div %0d freq %0d err %0d,",
								" got psc %0d div %0d freq %0d err %0d"}, n_checked,
								want.psc_code, want.div_code, want.freq, want.err,
								got.psc_code, got.div_code, got.freq, got.err);
					end
				end
			end
			if (target_valid && !target_stall)
				expected_fits.push_back(best_divider_fit(base_clock, target_frequency));
		end
		mismatches <= n_bad;
		outstanding <= expected_fits.size();
		results_checked <= n_checked;
	end

endmodule

// File: tb/sv/clock_divider_best_fit_search_top_tb.sv
// ----------------------------------------------------------------------------
// Clock divider best-fit search testbench
// Directed and random target items over a range of base clock settings, with
// random gaps and result stalls; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module clock_divider_best_fit_search_top_tb;
	import cdbfs_pkg::*;

	localparam int N_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int HOLD_OFF_CYCLES = 4000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [SRC_W-1:0]      cfg_wr_data;
	logic                  target_valid;
	logic                  target_stall;
	logic [TARGET_W-1:0]   target_frequency;
	logic                  result_valid;
	logic                  result_stall;
	logic [PSC_CODE_W-1:0] prescaler_code;
	logic [DIV_IDX_W-1:0]  divisor_code;
	logic [FREQ_W-1:0]     achieved_frequency;
	logic [ERR_W-1:0]      frequency_error;

	int               mismatches;
	int               outstanding;
	int               results_checked;
	int               items_sent = 0;
	int               settings_used = 1;
	bit               held_off = 1'b0;
	logic [SRC_W-1:0] clock_now = SRC_RESET;

	clock_divider_best_fit_search_top uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.target_valid       (target_valid),
		.target_stall       (target_stall),
		.target_frequency   (target_frequency),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.prescaler_code     (prescaler_code),
		.divisor_code       (divisor_code),
		.achieved_frequency (achieved_frequency),
		.frequency_error    (frequency_error)
	);

	clock_divider_best_fit_search_checker fit_monitor (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.target_valid       (target_valid),
		.target_stall       (target_stall),
		.target_frequency   (target_frequency),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.prescaler_code     (prescaler_code),
		.divisor_code       (divisor_code),
		.achieved_frequency (achieved_frequency),
		.frequency_error    (frequency_error),
		.mismatches         (mismatches),
		.outstanding        (outstanding),
		.results_checked    (results_checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 90)
			return $urandom_range(3, 40);
		else
			return $urandom_range(100, 700);
	endfunction

	// mostly targets close to, or midway between, achievable frequencies
	function automatic logic [TARGET_W-1:0] pick_target(input logic [SRC_W-1:0] src);
		int unsigned r;
		int unsigned div_a;
		int unsigned div_b;
		longint      t;
		r = $urandom_range(0, 99);
		div_a = (2 << $urandom_range(0, 7)) * $urandom_range(1, 16);
		div_b = (2 << $urandom_range(0, 7)) * $urandom_range(1, 16);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: t = 0;
				1: t = 1;
				2: t = 400_000_000;
				default: t = (1 << TARGET_W) - 1;
			endcase
		end else if (r < 50)
			t = longint'(src / div_a) + longint'($urandom_range(0, 6)) - 3;
		else if (r < 65)
			t = (longint'(src / div_a) + longint'(src / div_b)) / 2;
		else if (r < 97)
			t = $urandom_range(0, 400_000_000);
		else
			t = $urandom_range(0, (1 << TARGET_W) - 1);
		if (t < 0)
			t = 0;
		return TARGET_W'(t);
	endfunction

	task automatic send_target(input logic [TARGET_W-1:0] f);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			target_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		target_valid     <= 1'b1;
		target_frequency <= f;
		@(posedge clk);
		while (target_stall) @(posedge clk);
		items_sent++;
	endtask

	// only once the block has drained
	task automatic set_base_clock(input logic [SRC_W-1:0] v);
		target_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clock_now = v;
		settings_used++;
	endtask

	initial begin : stimulus
		logic [TARGET_W-1:0] probes[17];
		logic [SRC_W-1:0]    phase_clocks[N_PHASES];
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		target_valid     = 1'b0;
		target_frequency = '0;
		result_stall     = 1'b0;
		probes = '{29'd0, 29'd1, 29'h1FFF_FFFF, 29'd400_000_000, 29'd60_000_000,
			29'd60_000_001, 29'd59_999_999, 29'd45_000_000, 29'd35_000_000,
			29'd20_000_000, 29'd400_000, 29'd25_000_000, 29'd234_375, 29'd29_296,
			29'h0AAA_AAAA, 29'h1555_5555, 29'd100};
		phase_clocks = '{29'd0, 29'd1, 29'd3, 29'd4095, 29'd400_000_000, 29'h1FFF_FFFF,
			29'd48_000_000, SRC_W'($urandom_range(1, (1 << SRC_W) - 1)),
			SRC_W'($urandom_range(1000, 200_000_000)),
			SRC_W'($urandom_range(1, 1_000_000))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_target(probes[i]);
		for (int ph = 0; ph <= N_PHASES; ph++) begin
			if (ph > 0)
				set_base_clock(phase_clocks[ph - 1]);
			send_target('0);
			for (int i = 1; i < ITEMS_PER_PHASE; i++)
				send_target(pick_target(clock_now));
		end

		target_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		$display("Searched %0d targets under %0d base clock settings, %0d results scored.",
			items_sent, settings_used, results_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		int unsigned r;
		int unsigned span;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held_off && results_checked >= 200) begin
				// long hold-off so the block fills and stalls its input
				held_off = 1'b1;
				result_stall <= 1'b1;
				span = HOLD_OFF_CYCLES;
			end else if (r < 40) begin
				result_stall <= 1'b0;
				span = $urandom_range(1, 4);
			end else if (r < 60) begin
				result_stall <= 1'b1;
				span = $urandom_range(1, 4);
			end else if (r < 75) begin
				result_stall <= 1'b0;
				span = $urandom_range(100, 1500);
			end else if (r < 92) begin
				result_stall <= 1'b1;
				span = $urandom_range(20, 300);
			end else begin
				result_stall <= 1'b1;
				span = $urandom_range(600, 1500);
			end
			repeat (span) @(posedge clk);
		end
	end

	initial begin : watchdog
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
